@@ rtl/rtxq_pkg.sv @@
// ----------------------------------------------------------------------------
// rtxq_pkg
// Shared types, palette constants and helper functions for the RGB to
// xterm 256-colour quantiser.
// ----------------------------------------------------------------------------
package rtxq_pkg;

	typedef logic [7:0]  chan_t;   // one colour channel or palette index
	typedef logic [2:0]  level_t;  // cube level 0..5
	typedef logic [4:0]  gstep_t;  // grey ramp step 0..23
	typedef logic [9:0]  csum_t;   // sum of three channels
	typedef logic [15:0] sq_t;     // square of an 8-bit difference
	typedef logic [17:0] dist_t;   // sum of three squares

	localparam int unsigned PIPE_DEPTH = 5;

	localparam chan_t  CUBE_BASE   = 8'd16;
	localparam chan_t  GREY_BASE   = 8'd232;
	localparam gstep_t GREY_STEP_MAX = 5'd23;   // step 24 saturates to index 255
	localparam csum_t  GREY_LO_SUM = 10'd24;    // at or below: darkest grey
	localparam csum_t  GREY_HI_SUM = 10'd714;   // at or above: brightest grey
	localparam logic [9:0] GREY_RECIP = 10'd570; // ceil(2^16 / 115)
	localparam int unsigned GREY_SHIFT = 16;

	// Round a channel to its cube level, (v + 25) / 51, by threshold compare
	function automatic level_t cube_level(input chan_t v);
		level_t k;
		k = 3'd0;
		if (v >= 8'd26)  k = 3'd1;
		if (v >= 8'd77)  k = 3'd2;
		if (v >= 8'd128) k = 3'd3;
		if (v >= 8'd179) k = 3'd4;
		if (v >= 8'd230) k = 3'd5;
		return k;
	endfunction

	// Expand a cube level back to its channel value, 55 + 40k
	function automatic chan_t cube_value(input level_t k);
		chan_t c;
		case (k)
			3'd0: c = 8'd55;
			3'd1: c = 8'd95;
			3'd2: c = 8'd135;
			3'd3: c = 8'd175;
			3'd4: c = 8'd215;
			3'd5: c = 8'd255;
			default: c = 8'd55;
		endcase
		return c;
	endfunction

	// Absolute difference of two channels
	function automatic chan_t abs_diff(input chan_t a, input chan_t b);
		return (a > b) ? (a - b) : (b - a);
	endfunction

endpackage

@@ rtl/rgb_to_xterm256_quantizer_core.sv @@
// ----------------------------------------------------------------------------
// rgb_to_xterm256_quantizer_core
// Maps one 24-bit RGB pixel to the nearest xterm palette index, choosing
// between a 6x6x6 cube entry and a greyscale ramp entry.
// ----------------------------------------------------------------------------
// A pixel is taken on every clock edge at which start is high; busy never
// rises, so one pixel per clock is sustained. The result appears on
// palette_index with done high for one cycle, after the pixel has passed
// the five register stages: level and sum, grey step multiply, expansion
// and differences, squares, distance compare. The receiver cannot stall
// the block, so no result is ever held back.
module rgb_to_xterm256_quantizer_core
	import rtxq_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [7:0] red,
	input  logic [7:0] green,
	input  logic [7:0] blue,
	output logic [7:0] palette_index,
	output logic       done
);

	// Valid bits
	logic v_s1, v_s2, v_s3, v_s4, v_s5;

	// Stage 1 payload
	chan_t  r_s1, g_s1, b_s1;
	level_t kr_s1, kg_s1, kb_s1;
	csum_t  sum_s1;

	// Stage 2 payload
	chan_t  r_s2, g_s2, b_s2;
	chan_t  cr_s2, cg_s2, cb_s2;
	chan_t  cube_s2;
	gstep_t gs_s2;

	// Stage 3 payload
	chan_t  dcr_s3, dcg_s3, dcb_s3;
	chan_t  dgr_s3, dgg_s3, dgb_s3;
	chan_t  cube_s3;
	gstep_t gs_s3;

	// Stage 4 payload
	sq_t    qcr_s4, qcg_s4, qcb_s4;
	sq_t    qgr_s4, qgg_s4, qgb_s4;
	chan_t  cube_s4;
	gstep_t gs_s4;

	// Stage 5 payload
	chan_t  pick_s5;

	// Grey step by reciprocal multiply
	logic [11:0] gx;
	logic [21:0] gprod;
	gstep_t      gs_d;
	always_comb begin
		gx    = {sum_s1 - GREY_LO_SUM, 2'b00};
		gprod = gx * GREY_RECIP;
		if (sum_s1 <= GREY_LO_SUM) begin
			gs_d = 5'd0;
		end else if (sum_s1 >= GREY_HI_SUM) begin
			gs_d = GREY_STEP_MAX;
		end else begin
			gs_d = gprod[GREY_SHIFT+4:GREY_SHIFT];
		end
	end

	// Cube index from the three levels
	chan_t cube_d;
	always_comb begin
		cube_d = CUBE_BASE + 8'(kr_s1) * 8'd36 + 8'(kg_s1) * 8'd6 + 8'(kb_s1);
	end

	// Grey level, 8 + 10 * step
	chan_t gl_d;
	always_comb begin
		gl_d = 8'd8 + 8'(gs_s2) * 8'd10;
	end

	// Distances; the choice is registered in stage 5
	dist_t dcube_d, dgrey_d;
	always_comb begin
		dcube_d = 18'(qcr_s4) + 18'(qcg_s4) + 18'(qcb_s4);
		dgrey_d = 18'(qgr_s4) + 18'(qgg_s4) + 18'(qgb_s4);
	end

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// Advance payload
	always_ff @(posedge clk) begin
		// stage 1: capture pixel, levels and sum
		r_s1   <= red;
		g_s1   <= green;
		b_s1   <= blue;
		kr_s1  <= cube_level(red);
		kg_s1  <= cube_level(green);
		kb_s1  <= cube_level(blue);
		sum_s1 <= 10'(red) + 10'(green) + 10'(blue);
		// stage 2: grey step, cube index and cube colour
		r_s2    <= r_s1;
		g_s2    <= g_s1;
		b_s2    <= b_s1;
		cr_s2   <= cube_value(kr_s1);
		cg_s2   <= cube_value(kg_s1);
		cb_s2   <= cube_value(kb_s1);
		cube_s2 <= cube_d;
		gs_s2   <= gs_d;
		// stage 3: channel differences
		dcr_s3  <= abs_diff(cr_s2, r_s2);
		dcg_s3  <= abs_diff(cg_s2, g_s2);
		dcb_s3  <= abs_diff(cb_s2, b_s2);
		dgr_s3  <= abs_diff(gl_d, r_s2);
		dgg_s3  <= abs_diff(gl_d, g_s2);
		dgb_s3  <= abs_diff(gl_d, b_s2);
		cube_s3 <= cube_s2;
		gs_s3   <= gs_s2;
		// stage 4: squares
		qcr_s4  <= dcr_s3 * dcr_s3;
		qcg_s4  <= dcg_s3 * dcg_s3;
		qcb_s4  <= dcb_s3 * dcb_s3;
		qgr_s4  <= dgr_s3 * dgr_s3;
		qgg_s4  <= dgg_s3 * dgg_s3;
		qgb_s4  <= dgb_s3 * dgb_s3;
		cube_s4 <= cube_s3;
		gs_s4   <= gs_s3;
		// stage 5: cube only when strictly nearer
		pick_s5 <= (dcube_d < dgrey_d) ? cube_s4 : (GREY_BASE + 8'(gs_s4));
	end

	assign busy          = 1'b0;
	assign done          = v_s5;
	assign palette_index = pick_s5;

endmodule

@@ rtl/rtxq_checker.sv @@
// ----------------------------------------------------------------------------
// rtxq_checker
// Port-level checks on the quantiser: latency, rate and result range.
// ----------------------------------------------------------------------------
module rtxq_checker
	import rtxq_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic [7:0] palette_index,
	input logic       done
);

	// Never hold off a pixel
	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");

	// Every pixel gives a result after the fixed latency
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##PIPE_DEPTH done)
		else $error("result missing after pixel");

	// No result without a pixel
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!start |-> ##PIPE_DEPTH !done)
		else $error("result without pixel");

	// Results lie in the cube or grey range
	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (palette_index >= CUBE_BASE))
		else $error("palette index below cube range");

endmodule

bind rgb_to_xterm256_quantizer_core rtxq_checker u_rtxq_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.palette_index (palette_index),
	.done          (done)
);
